[src/hkv_pkg.sv]
// hkv_pkg: field widths, operation and status codes, request and entry types
// shared by the key/value table interfaces and modules; no dependencies
package hkv_pkg;

  localparam int KEY_W    = 31;
  localparam int VAL_W    = 31;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [STATUS_W-1:0] status_t;

  // operation codes
  localparam mode_t MODE_PUT    = 2'd0;
  localparam mode_t MODE_GET    = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

  // result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_ABSENT = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

  typedef struct packed {
    mode_t mode;
    key_t  key;
    val_t  value;
  } req_t;

  // one way of a bucket row
  typedef struct packed {
    logic vld;
    key_t key;
    val_t value;
  } entry_t;

endpackage

[src/hkv_if.sv]
// hkv_if: valid/ready channel interfaces for requests and results
// depends on hkv_pkg for the field types
interface hkv_req_if;
  logic          valid;
  logic          ready;
  hkv_pkg::mode_t mode;
  hkv_pkg::key_t  key;
  hkv_pkg::val_t  value;

  modport source(output valid, output mode, output key, output value, input ready);
  modport sink(input valid, input mode, input key, input value, output ready);
endinterface

interface hkv_rsp_if;
  logic             valid;
  logic             ready;
  hkv_pkg::status_t status;
  hkv_pkg::val_t    read_value;

  modport source(output valid, output status, output read_value, input ready);
  modport sink(input valid, input status, input read_value, output ready);
endinterface

[src/hash_key_value_table_unit.sv]
// hash_key_value_table_unit: top level of the bucketed key/value table
// depends on hkv_pkg, hkv_if, hkv_hash and hkv_store
//
// Key/value table with BUCKETS buckets of WAYS entries each; the bucket of a
// request is key mod BUCKETS. Put, get and remove each give exactly one
// result: status 0 done/found, 1 key not present, 2 bucket full on put, and
// read_value holds the stored value on a successful get and zero otherwise.
// Sustained throughput is one request per cycle unless out_rsp.ready stalls the
// pipeline; after acceptance a request passes the input register, the bucket index
// arithmetic registers, a registered read of the whole bucket row from a one-read,
// one-write row memory, then lookup/update into the result register.
// After reset a clear pass writes every bucket row once, while
// in_req.ready stays low.
module hash_key_value_table_unit #(
  parameter int BUCKETS = 16,
  parameter int WAYS    = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  hkv_req_if.sink   in_req,
  hkv_rsp_if.source out_rsp
);

  localparam int               BKT_W    = $clog2(BUCKETS);
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKETS - 1);

  logic               clr_busy_r;
  logic [BKT_W-1:0]   clr_cnt_r;
  logic               bkt_valid, bkt_ready;
  hkv_pkg::req_t      bkt_req;
  logic [BKT_W-1:0]   bkt_idx;

  // clear pass sweeps one bucket row per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_BKT) clr_busy_r <= 1'b0;
    end
  end

  hkv_hash #(
    .BUCKETS(BUCKETS)
  ) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .hold     (clr_busy_r),
    .in_req   (in_req),
    .bkt_valid(bkt_valid),
    .bkt_ready(bkt_ready),
    .bkt_req  (bkt_req),
    .bkt_idx  (bkt_idx)
  );

  hkv_store #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy_r),
    .clr_addr (clr_cnt_r),
    .bkt_valid(bkt_valid),
    .bkt_ready(bkt_ready),
    .bkt_req  (bkt_req),
    .bkt_idx  (bkt_idx),
    .out_rsp  (out_rsp)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_req.ready)
    else $error("request accepted during clear pass");

endmodule

[src/hkv_hash.sv]
// hkv_hash: request input register and bucket index pipeline (key mod BUCKETS
// by reciprocal multiply); depends on hkv_pkg and hkv_if
module hkv_hash #(
  parameter int  BUCKETS = 16,
  localparam int BKT_W   = $clog2(BUCKETS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hold,
  hkv_req_if.sink            in_req,
  output logic               bkt_valid,
  input  logic               bkt_ready,
  output hkv_pkg::req_t      bkt_req,
  output logic [BKT_W-1:0]   bkt_idx
);

  localparam int          SHIFT      = hkv_pkg::KEY_W + BKT_W;
  localparam int          PROD_W     = hkv_pkg::KEY_W + 32;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
  localparam logic [BKT_W-1:0] BKT_LO = BKT_W'(BUCKETS);

  logic               s1_v_r, s2_v_r, s3_v_r;
  hkv_pkg::req_t      s1_req_r, s2_req_r, s3_req_r;
  logic [BKT_W-1:0]   s2_qlo_r, s3_bkt_r;
  logic               s1_rdy, s2_rdy, s3_rdy;
  logic [PROD_W-1:0]  prod;
  logic [BKT_W-1:0]   qb;
  logic [BKT_W-1:0]   bkt;

  assign s3_rdy = !s3_v_r || bkt_ready;
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign s1_rdy = !s1_v_r || s2_rdy;
  assign in_req.ready = s1_rdy && !hold;

  // quotient is exact for every 31-bit key; only its low bits are needed
  assign prod = PROD_W'(s1_req_r.key) * PROD_W'(RECIP);
  // remainder modulo 2^BKT_W equals the true remainder since it is below BUCKETS
  assign qb   = s2_qlo_r * BKT_LO;
  assign bkt  = s2_req_r.key[BKT_W-1:0] - qb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_req.valid && !hold;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_req_r <= '{mode: in_req.mode, key: in_req.key, value: in_req.value};
    end
    if (s2_rdy) begin
      s2_req_r <= s1_req_r;
      s2_qlo_r <= prod[SHIFT +: BKT_W];
    end
    if (s3_rdy) begin
      s3_req_r <= s2_req_r;
      s3_bkt_r <= bkt;
    end
  end

  assign bkt_valid = s3_v_r;
  assign bkt_req   = s3_req_r;
  assign bkt_idx   = s3_bkt_r;

  a_bkt_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> ({1'b0, s3_bkt_r} < (BKT_W+1)'(BUCKETS)))
    else $error("bucket index out of range");

endmodule

[src/hkv_store.sv]
// hkv_store: bucket row memory, lookup/update stage with write forwarding and
// the result register; depends on hkv_pkg and hkv_if
module hkv_store #(
  parameter int  BUCKETS = 16,
  parameter int  WAYS    = 4,
  localparam int BKT_W   = $clog2(BUCKETS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr_busy,
  input  logic [BKT_W-1:0]   clr_addr,
  input  logic               bkt_valid,
  output logic               bkt_ready,
  input  hkv_pkg::req_t      bkt_req,
  input  logic [BKT_W-1:0]   bkt_idx,
  hkv_rsp_if.source          out_rsp
);

  hkv_pkg::entry_t [WAYS-1:0] mem [BUCKETS];

  logic                        c_v_r;
  hkv_pkg::req_t               c_req_r;
  logic [BKT_W-1:0]            c_bkt_r;
  hkv_pkg::entry_t [WAYS-1:0]  rd_row_r;
  logic                        fwd_v_r;
  hkv_pkg::entry_t [WAYS-1:0]  fwd_row_r;
  logic                        out_v_r;
  hkv_pkg::status_t            status_r;
  hkv_pkg::val_t               rdval_r;

  logic                        o_rdy, c_rdy, c_fire, rd_en;
  hkv_pkg::entry_t [WAYS-1:0]  row_eff, new_row, wr_row;
  logic [WAYS-1:0]             vld, hit, hit_oh, free_oh;
  logic                        wr_item, wr_en;
  logic [BKT_W-1:0]            wr_addr;
  hkv_pkg::status_t            status_nxt;
  hkv_pkg::val_t               rdval_nxt;

  assign o_rdy     = !out_v_r || out_rsp.ready;
  assign c_rdy     = !c_v_r || o_rdy;
  assign c_fire    = c_v_r && o_rdy;
  assign bkt_ready = c_rdy && !clr_busy;
  assign rd_en     = bkt_valid && bkt_ready;

  // the previous transaction's write lands at the edge this row was read
  assign row_eff = fwd_v_r ? fwd_row_r : rd_row_r;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      vld[w] = row_eff[w].vld;
      hit[w] = row_eff[w].vld && (row_eff[w].key == c_req_r.key);
    end
    hit_oh  = hit & (~hit + 1'b1);
    free_oh = ~vld & (vld + 1'b1);
  end

  always_comb begin
    new_row    = row_eff;
    wr_item    = 1'b0;
    status_nxt = hkv_pkg::ST_ABSENT;
    rdval_nxt  = '0;
    unique case (c_req_r.mode)
      hkv_pkg::MODE_PUT: begin
        if (|hit) begin
          for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) new_row[w].value = c_req_r.value;
          end
          wr_item    = 1'b1;
          status_nxt = hkv_pkg::ST_OK;
        end else if (|free_oh) begin
          for (int w = 0; w < WAYS; w++) begin
            if (free_oh[w]) begin
              new_row[w] = '{vld: 1'b1, key: c_req_r.key, value: c_req_r.value};
            end
          end
          wr_item    = 1'b1;
          status_nxt = hkv_pkg::ST_OK;
        end else begin
          status_nxt = hkv_pkg::ST_FULL;
        end
      end
      hkv_pkg::MODE_GET: begin
        if (|hit) begin
          for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) rdval_nxt = rdval_nxt | row_eff[w].value;
          end
          status_nxt = hkv_pkg::ST_OK;
        end
      end
      hkv_pkg::MODE_REMOVE: begin
        if (|hit) begin
          for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) new_row[w].vld = 1'b0;
          end
          wr_item    = 1'b1;
          status_nxt = hkv_pkg::ST_OK;
        end
      end
      default: begin
        status_nxt = hkv_pkg::ST_ABSENT;
      end
    endcase
  end

  // clear pass owns the write port after reset
  assign wr_en   = clr_busy || (c_fire && wr_item);
  assign wr_addr = clr_busy ? clr_addr : c_bkt_r;
  assign wr_row  = clr_busy ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_row_r <= mem[bkt_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r   <= 1'b0;
      fwd_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (c_rdy) c_v_r <= rd_en;
      if (rd_en) begin
        fwd_v_r <= c_fire && wr_item && (c_bkt_r == bkt_idx);
      end else if (c_fire) begin
        fwd_v_r <= 1'b0;
      end
      if (o_rdy) out_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      c_req_r   <= bkt_req;
      c_bkt_r   <= bkt_idx;
      fwd_row_r <= new_row;
    end
    if (c_fire) begin
      status_r <= status_nxt;
      rdval_r  <= rdval_nxt;
    end
  end

  assign out_rsp.valid      = out_v_r;
  assign out_rsp.status     = status_r;
  assign out_rsp.read_value = rdval_r;

  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> $onehot0(hit))
    else $error("key stored in more than one way of a bucket");

  a_fwd_owner: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_v_r |-> c_v_r)
    else $error("forwarded row with no transaction in lookup stage");

  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> (!c_v_r && !bkt_ready))
    else $error("lookup activity during clear pass");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for hash_key_value_table_unit (put/get/remove table)
// depends on hkv_pkg, hkv_if and the unit itself; keeps its own copy of the table
// to predict each result and compares it with every result transaction in order
module tb_top;

  localparam int BUCKETS     = 16;
  localparam int WAYS        = 4;
  localparam int ENTRIES     = BUCKETS * WAYS;
  localparam int LATENCY     = 4;
  localparam int STALL_LEN   = 120;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int POOL_SIZE   = 32;
  localparam int HOT_COUNT   = 5;

  localparam hkv_pkg::mode_t MODE_UNUSED = 2'd3;
  localparam hkv_pkg::key_t  KEY_MAX     = '1;
  localparam hkv_pkg::val_t  VAL_MAX     = '1;

  typedef struct {
    hkv_pkg::req_t req;
    int            phase;
    bit            wait_drain;
    bit            stall_rx;
  } stim_t;

  typedef struct packed {
    hkv_pkg::status_t status;
    hkv_pkg::val_t    read_value;
  } reply_t;

  logic clk;
  logic rst_n;

  hkv_req_if req_ch();
  hkv_rsp_if rsp_ch();

  hash_key_value_table_unit #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  // shadow of the table contents
  bit            tbl_valid[ENTRIES];
  hkv_pkg::key_t tbl_key[ENTRIES];
  hkv_pkg::val_t tbl_value[ENTRIES];

  stim_t  request_queue[$];
  reply_t reply_queue[$];

  hkv_pkg::key_t key_pool[POOL_SIZE];
  bit [3:0]      hot_bucket[HOT_COUNT];

  bit req_taken;
  int drive_phase;
  int stall_requests;
  int stall_served;
  int stall_left;
  int fail_count;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic int send_idle_pct(int ph);
    case (ph)
      0: return 37;
      1: return 77;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct(int ph);
    case (ph)
      0: return 77;
      1: return 37;
      default: return 0;
    endcase
  endfunction

  // applies one request to the shadow table and returns the result it gives
  function automatic reply_t apply_request(hkv_pkg::req_t rq);
    int base;
    int hit;
    int slot;
    reply_t r;
    base = int'(rq.key % BUCKETS) * WAYS;
    hit  = -1;
    slot = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (hit < 0 && tbl_valid[base+w] && tbl_key[base+w] == rq.key) hit = w;
      if (slot < 0 && !tbl_valid[base+w]) slot = w;
    end
    r.status     = hkv_pkg::ST_ABSENT;
    r.read_value = '0;
    case (rq.mode)
      hkv_pkg::MODE_PUT: begin
        if (hit >= 0) begin
          tbl_value[base+hit] = rq.value;
          r.status = hkv_pkg::ST_OK;
        end else if (slot >= 0) begin
          tbl_valid[base+slot] = 1'b1;
          tbl_key[base+slot]   = rq.key;
          tbl_value[base+slot] = rq.value;
          r.status = hkv_pkg::ST_OK;
        end else begin
          r.status = hkv_pkg::ST_FULL;
        end
      end
      hkv_pkg::MODE_GET: begin
        if (hit >= 0) begin
          r.read_value = tbl_value[base+hit];
          r.status     = hkv_pkg::ST_OK;
        end
      end
      hkv_pkg::MODE_REMOVE: begin
        if (hit >= 0) begin
          tbl_valid[base+hit] = 1'b0;
          r.status = hkv_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_item(hkv_pkg::mode_t m, hkv_pkg::key_t k, hkv_pkg::val_t v, int ph,
                          bit drain, bit stall);
    stim_t s;
    s.req.mode   = m;
    s.req.key    = k;
    s.req.value  = v;
    s.phase      = ph;
    s.wait_drain = drain;
    s.stall_rx   = stall;
    request_queue.push_back(s);
  endtask

  // keys crowd into a few hot buckets so that hits, misses and full buckets all occur
  function automatic hkv_pkg::key_t hot_key();
    return {27'($urandom), hot_bucket[$urandom_range(0, HOT_COUNT-1)]};
  endfunction

  task automatic add_random_phase(int ph, int n);
    int r;
    hkv_pkg::mode_t m;
    hkv_pkg::key_t k;
    hkv_pkg::val_t v;
    for (int i = 0; i < HOT_COUNT; i++) hot_bucket[i] = 4'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = hot_key();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) m = hkv_pkg::MODE_PUT;
      else if (r < 75) m = hkv_pkg::MODE_GET;
      else if (r < 95) m = hkv_pkg::MODE_REMOVE;
      else m = MODE_UNUSED;
      if ($urandom_range(0, 9) == 0) k = hkv_pkg::key_t'($urandom);
      else k = key_pool[$urandom_range(0, POOL_SIZE-1)];
      if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, POOL_SIZE-1)] = hot_key();
      r = $urandom_range(0, 19);
      if (r == 0) v = '0;
      else if (r == 1) v = VAL_MAX;
      else v = hkv_pkg::val_t'($urandom);
      add_item(m, k, v, ph, (i == 0) && (ph != 0), (i == n/2) && (ph != 1));
    end
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  initial begin
    // directed: field extremes, overwrite, misses, filling a bucket, removal from it, unused code
    add_item(hkv_pkg::MODE_PUT,    '0,      '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_PUT,    KEY_MAX, VAL_MAX, 0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    '0,      VAL_MAX, 0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    KEY_MAX, '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_PUT,    '0,      VAL_MAX, 0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    '0,      '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    31'd16,  '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_REMOVE, 31'd16,  '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_PUT,    31'd15,  31'd1,   0, 0, 0);
    add_item(hkv_pkg::MODE_PUT,    31'd31,  31'd2,   0, 0, 0);
    add_item(hkv_pkg::MODE_PUT,    31'd47,  31'd3,   0, 0, 0);
    add_item(hkv_pkg::MODE_PUT,    31'd63,  31'd4,   0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    31'd63,  '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_REMOVE, 31'd31,  '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_PUT,    31'd63,  31'd5,   0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    31'd63,  '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    31'd31,  '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_REMOVE, '0,      '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    '0,      '0,      0, 0, 0);
    add_item(MODE_UNUSED,          KEY_MAX, VAL_MAX, 0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    KEY_MAX, '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_PUT,    KEY_MAX, '0,      0, 0, 0);
    add_item(hkv_pkg::MODE_GET,    KEY_MAX, '0,      0, 0, 0);
    add_random_phase(0, 200);
    add_random_phase(1, 200);
    add_random_phase(2, 200);

    @(posedge rst_n);
    while (request_queue.size() != 0 || req_ch.valid || reply_queue.size() != 0)
      @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // request driver
  always @(negedge clk) begin : drive_req
    stim_t nxt;
    bit send;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      send = 1'b0;
      if (request_queue.size() != 0) begin
        nxt = request_queue[0];
        // a draining item waits until every outstanding result has come back
        if (!(nxt.wait_drain && reply_queue.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct(nxt.phase))
          send = 1'b1;
      end
      if (send) begin
        void'(request_queue.pop_front());
        req_ch.valid <= 1'b1;
        req_ch.mode  <= nxt.req.mode;
        req_ch.key   <= nxt.req.key;
        req_ch.value <= nxt.req.value;
        drive_phase  <= nxt.phase;
        if (nxt.stall_rx) stall_requests <= stall_requests + 1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on request so the pipeline backs up
  always @(negedge clk) begin : drive_rsp_ready
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left   <= STALL_LEN;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct(drive_phase));
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin : monitor
    reply_t want;
    bit in_fire;
    bit out_fire;
    in_fire  = rst_n && ((req_ch.valid & req_ch.ready) === 1'b1);
    out_fire = rst_n && ((rsp_ch.valid & rsp_ch.ready) === 1'b1);
    req_taken <= in_fire;
    if (in_fire)
      reply_queue.push_back(apply_request('{mode: req_ch.mode, key: req_ch.key,
                                             value: req_ch.value}));
    if (out_fire) begin
      if (reply_queue.size() == 0) begin
        note_failure($sformatf("result transaction with none expected: status %0d value %h",
                               rsp_ch.status, rsp_ch.read_value));
      end else begin
        want = reply_queue.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.read_value)
          note_failure($sformatf("status exp %0d got %0d, read_value exp %h got %h",
                                 want.status, rsp_ch.status,
                                 want.read_value, rsp_ch.read_value));
      end
    end
    if (in_fire || out_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin : watchdog
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
